### rtl/core/tta_pkg.sv
package tta_pkg;

  localparam int unsigned CordicW = 48;
  localparam int unsigned AngleW = 32;

  typedef enum logic [2:0] {
    REG_AXLE_DIST  = 3'd0,
    REG_MAX_SPEED  = 3'd1,
    REG_MAX_STEER  = 3'd2,
    REG_ALLOW_REV  = 3'd3,
    REG_FWD_GEAR   = 3'd4,
    REG_REV_GEAR   = 3'd5,
    REG_TIMEOUT    = 3'd6,
    REG_PERIOD     = 3'd7
  } reg_idx_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } dp_cmd_t;

  // Arctangent of 2^-i in centidegrees scaled by 2^16.
  function automatic logic [AngleW-1:0] atan_lut(input logic [4:0] idx);
    logic [AngleW-1:0] v;
    case (idx)
      5'd0:  v = 32'd294912000;
      5'd1:  v = 32'd174096719;
      5'd2:  v = 32'd91987925;
      5'd3:  v = 32'd46694507;
      5'd4:  v = 32'd23437865;
      5'd5:  v = 32'd11730358;
      5'd6:  v = 32'd5866610;
      5'd7:  v = 32'd2933484;
      5'd8:  v = 32'd1466764;
      5'd9:  v = 32'd733385;
      5'd10: v = 32'd366693;
      5'd11: v = 32'd183346;
      5'd12: v = 32'd91673;
      5'd13: v = 32'd45837;
      5'd14: v = 32'd22918;
      5'd15: v = 32'd11459;
      5'd16: v = 32'd5730;
      5'd17: v = 32'd2865;
      5'd18: v = 32'd1432;
      5'd19: v = 32'd716;
      5'd20: v = 32'd358;
      5'd21: v = 32'd179;
      5'd22: v = 32'd90;
      5'd23: v = 32'd45;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/tta_cordic.sv
module tta_cordic (
  input  logic                 clk,
  input  tta_pkg::dp_cmd_t     cmd,
  input  logic [4:0]           step_idx,
  input  logic [14:0]          abs_v,
  input  logic [15:0]          abs_w,
  input  logic [11:0]          axle_dist,
  input  logic [13:0]          max_steer,
  output logic [13:0]          angle
);

  localparam int unsigned W = tta_pkg::CordicW;

  logic signed [W-1:0] x_r, y_r;
  logic signed [tta_pkg::AngleW+1:0] z_r;
  logic [13:0] angle_r;
  logic signed [W-1:0] dx, dy;
  logic signed [tta_pkg::AngleW+1:0] tab, zr;
  logic signed [tta_pkg::AngleW-15:0] rnd;
  logic [27:0] prod_v, prod_w;

  assign prod_v = 28'(abs_v) * 28'd1000;
  assign prod_w = 28'(axle_dist) * 28'(abs_w);
  assign dx = y_r >>> step_idx;
  assign dy = x_r >>> step_idx;
  assign tab = $signed({2'b00, tta_pkg::atan_lut(step_idx)});
  assign zr = z_r + 34'sd32768;
  assign rnd = zr[tta_pkg::AngleW+1:16];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r <= $signed({12'd0, prod_v, 8'd0});
      y_r <= $signed({12'd0, prod_w, 8'd0});
      z_r <= '0;
    end else if (cmd.step) begin
      if (!y_r[W-1]) begin
        x_r <= x_r + dx; y_r <= y_r - dy; z_r <= z_r + tab;
      end else begin
        x_r <= x_r - dx; y_r <= y_r + dy; z_r <= z_r - tab;
      end
    end
    if (cmd.finish) begin
      if (rnd < 0) angle_r <= '0;
      else if (rnd > $signed({6'd0, max_steer})) angle_r <= max_steer;
      else angle_r <= rnd[13:0];
    end
  end

  assign angle = angle_r;

endmodule

### rtl/core/tta_ctrl.sv
module tta_ctrl #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output logic             done,
  output tta_pkg::dp_cmd_t cmd,
  output logic [4:0]       step_idx
);

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_ITER, S_FIN} state_t;
  state_t state_r;
  logic [4:0] cnt_r;
  logic done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= '0; done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        S_IDLE: if (start) state_r <= S_LOAD;
        S_LOAD: begin cnt_r <= '0; state_r <= S_ITER; end
        S_ITER: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(CORDIC_STEPS - 1)) state_r <= S_FIN;
        end
        S_FIN: begin done_r <= 1'b1; state_r <= S_IDLE; end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE) || done_r;
  assign done = done_r;
  assign step_idx = cnt_r;
  assign cmd.load = (state_r == S_LOAD);
  assign cmd.step = (state_r == S_ITER);
  assign cmd.finish = (state_r == S_FIN);

endmodule

### rtl/core/twist_to_ackermann_watchdog.sv
// Converts velocity commands to gear, speed and steering, and republishes the
// held command once per publish period of tick transfers, forcing a stop when
// no command has arrived or it has grown older than the timeout. A moving
// command passes from its transfer through a load step, CORDIC_STEPS rotations
// of the single shared CORDIC unit, a rounding step and a write-back step
// before the next input transfer can happen; a stop command needs no CORDIC
// work. One item is worked on at a time, and the input waits while a result
// sits in the result register and is not taken.
module twist_to_ackermann_watchdog #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_req_type,
  input  logic signed [15:0] in_linear_velocity,
  input  logic signed [15:0] in_yaw_rate,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_gear,
  output logic [14:0]        out_speed,
  output logic signed [14:0] out_steering,
  output logic               out_stop_forced,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  logic [11:0] axle_dist_r;
  logic [14:0] max_speed_r;
  logic [13:0] max_steer_r;
  logic        allow_rev_r;
  logic [7:0]  fwd_gear_r, rev_gear_r;
  logic [15:0] timeout_r, period_r;

  logic        have_cmd_r;
  logic [15:0] age_r, pcount_r;
  logic [7:0]  held_gear_r;
  logic [14:0] held_speed_r;
  logic signed [14:0] held_steer_r;

  logic        negate_r, pend_rev_r;
  logic [14:0] abs_v_r;
  logic [15:0] abs_w_r;

  logic        out_valid_r;
  logic [7:0]  out_gear_r;
  logic [14:0] out_speed_r;
  logic signed [14:0] out_steer_r;
  logic        out_stop_r;

  tta_pkg::dp_cmd_t cmd;
  logic [4:0]  step_idx;
  logic        busy, done, start;
  logic [13:0] angle;

  logic        in_acc, is_tick;
  logic signed [16:0] v_sat, lim;
  logic [15:0] age_inc, pcount_inc;
  logic        publish;

  assign cfg_ready = 1'b1;
  assign in_ready = !busy && (!out_valid_r || out_ready);
  assign in_acc = in_valid && in_ready;
  assign is_tick = in_req_type;

  assign lim = $signed({2'b00, max_speed_r});
  always_comb begin
    v_sat = 17'(in_linear_velocity);
    if (v_sat > lim) v_sat = lim;
    if (v_sat < -lim) v_sat = -lim;
  end

  assign age_inc = (age_r == 16'hFFFF) ? age_r : age_r + 16'd1;
  assign pcount_inc = pcount_r + 16'd1;
  assign publish = pcount_inc >= period_r;
  assign start = in_acc && !is_tick && !((v_sat < 0 && !allow_rev_r) || v_sat == 0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axle_dist_r <= 12'd600; max_speed_r <= 15'd300; max_steer_r <= 14'd2500;
      allow_rev_r <= 1'b0; fwd_gear_r <= 8'd1; rev_gear_r <= 8'd2;
      timeout_r <= 16'd300; period_r <= 16'd20;
      have_cmd_r <= 1'b0; age_r <= '0; pcount_r <= '0;
      held_gear_r <= 8'd1; held_speed_r <= '0; held_steer_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tta_pkg::REG_AXLE_DIST:  axle_dist_r <= cfg_data[11:0];
          tta_pkg::REG_MAX_SPEED:  max_speed_r <= cfg_data[14:0];
          tta_pkg::REG_MAX_STEER:  max_steer_r <= cfg_data[13:0];
          tta_pkg::REG_ALLOW_REV:  allow_rev_r <= cfg_data[0];
          tta_pkg::REG_FWD_GEAR:   fwd_gear_r <= cfg_data[7:0];
          tta_pkg::REG_REV_GEAR:   rev_gear_r <= cfg_data[7:0];
          tta_pkg::REG_TIMEOUT:    timeout_r <= cfg_data;
          tta_pkg::REG_PERIOD:     period_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid_r && out_ready && !(in_acc && is_tick && publish))
        out_valid_r <= 1'b0;
      if (in_acc && is_tick) begin
        age_r <= age_inc;
        pcount_r <= publish ? '0 : pcount_inc;
        if (publish) begin
          out_valid_r <= 1'b1;
          if (!have_cmd_r || age_inc > timeout_r) begin
            out_gear_r <= fwd_gear_r; out_speed_r <= '0;
            out_steer_r <= '0; out_stop_r <= 1'b1;
          end else begin
            out_gear_r <= held_gear_r; out_speed_r <= held_speed_r;
            out_steer_r <= held_steer_r; out_stop_r <= 1'b0;
          end
        end
      end else if (in_acc) begin
        have_cmd_r <= 1'b1;
        age_r <= '0;
        if (!start) begin
          held_gear_r <= fwd_gear_r; held_speed_r <= '0; held_steer_r <= '0;
        end
      end
      if (done) begin
        held_gear_r <= pend_rev_r ? rev_gear_r : fwd_gear_r;
        held_speed_r <= abs_v_r;
        held_steer_r <= negate_r ? -$signed({1'b0, angle}) : $signed({1'b0, angle});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      abs_v_r <= v_sat[16] ? 15'(-v_sat) : v_sat[14:0];
      abs_w_r <= in_yaw_rate[15] ? 16'(-in_yaw_rate) : in_yaw_rate;
      negate_r <= in_yaw_rate[15] != v_sat[16];
      pend_rev_r <= v_sat[16];
    end
  end

  tta_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk, .rst_n, .start, .busy, .done, .cmd, .step_idx
  );

  tta_cordic u_cordic (
    .clk, .cmd, .step_idx, .abs_v(abs_v_r), .abs_w(abs_w_r),
    .axle_dist(axle_dist_r), .max_steer(max_steer_r), .angle
  );

  assign out_valid = out_valid_r;
  assign out_gear = out_gear_r;
  assign out_speed = out_speed_r;
  assign out_steering = out_steer_r;
  assign out_stop_forced = out_stop_r;

  // A forced stop always carries zero speed.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stop_forced |-> out_speed == '0)
    else $error("forced stop with nonzero speed");
  // No item enters while the CORDIC unit is working.
  assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ready)
    else $error("input ready while busy");
  // A command transfer never produces a result.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_req_type && !out_valid |=> !out_valid)
    else $error("result after command");

endmodule
